// ----- src/imh_pkg.sv -----
// imh_pkg: action and status codes and payload widths for the indexed min-heap.
// No dependencies; used by the interfaces and by indexed_min_heap_top.
package imh_pkg;
    localparam int ACT_W = 3;
    localparam int HDL_IN_W = 13;
    localparam int VAL_W = 32;
    localparam int CNT_OUT_W = 11;
    localparam int STAT_W = 2;

    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PEEK = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DEL_MIN = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_HDL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CHG_HDL = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_HDL = 2'd3;
endpackage

// ----- src/imh_in_if.sv -----
// imh_in_if: request channel (valid/ready plus action, handle, new value).
// Depends on imh_pkg for field widths.
interface imh_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [imh_pkg::ACT_W-1:0]             action;
    logic [imh_pkg::HDL_IN_W-1:0]          handle;
    logic signed [imh_pkg::VAL_W-1:0]      new_value;
    modport source(output valid, action, handle, new_value, input ready);
    modport sink(input valid, action, handle, new_value, output ready);
endinterface

// ----- src/imh_out_if.sv -----
// imh_out_if: result channel (valid/ready plus minimum, count and status).
// Depends on imh_pkg for field widths.
interface imh_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [imh_pkg::VAL_W-1:0]      min_value;
    logic                                  min_valid;
    logic [imh_pkg::CNT_OUT_W-1:0]         entry_count;
    logic [imh_pkg::STAT_W-1:0]            status;
    modport source(output valid, min_value, min_valid, entry_count, status, input ready);
    modport sink(input valid, min_value, min_valid, entry_count, status, output ready);
endinterface

// ----- src/indexed_min_heap_top.sv -----
// Indexed binary min-heap: keys, slot->handle and handle->slot in three RAMs.
// A peek or a rejected item goes straight to the result register, a dead handle after the
// handle->slot read; removal of the last slot skips sifting, and other items sift up level
// by level, then down level by level. One item at a time; the next transfer is
// taken the cycle after the result is registered.
// Reset (synchronous, active low) clears counts and control; RAMs are not cleared.
// Depends on imh_pkg, imh_in_if, imh_out_if and imh_ram.
module indexed_min_heap_top #(
    parameter int HEAP_DEPTH = 1024,
    parameter int MAX_HANDLES = 4096,
    parameter int KEY_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    imh_in_if.sink    i_req,
    imh_out_if.source o_rsp
);
    import imh_pkg::*;

    // slot values 1..HEAP_DEPTH; slot 0 in handle->slot marks a dead handle
    localparam int SW = $clog2(HEAP_DEPTH + 1);
    localparam int HW = $clog2(MAX_HANDLES + 1);
    localparam int CW = (HW > HDL_IN_W) ? HW : HDL_IN_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DM_HD, S_HS_RD, S_RM_LAST, S_UP_RD, S_UP_CMP,
        S_DN_RD, S_DN_L, S_DN_SEL, S_PLACE, S_FIN
    } t_state;

    t_state r_state;
    logic [ACT_W-1:0]           r_act;
    logic [SW-1:0]              r_cnt, r_pos, r_p;
    logic [HW-1:0]              r_iss, r_hd, r_hdl, r_hl;
    logic signed [KEY_BITS-1:0] r_key, r_kl, r_min, r_nkey;
    logic                       r_rok;
    logic [STAT_W-1:0]          r_status;
    logic                       r_ov;
    logic signed [VAL_W-1:0]    r_omin;
    logic                       r_omv;
    logic [CNT_OUT_W-1:0]       r_ocnt;
    logic [STAT_W-1:0]          r_ost;

    // RAM ports
    logic                k_we, s_we, h_we;
    logic [SW-1:0]       k_wa, k_ra, s_wa, s_ra, h_wd, h_rd;
    logic [HW-1:0]       h_wa, h_ra, s_wd, s_rd;
    logic [KEY_BITS-1:0] k_wd, k_rd;

    imh_ram #(.WIDTH(KEY_BITS), .DEPTH(HEAP_DEPTH + 1)) u_key (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_wa), .i_wdata(k_wd),
        .i_raddr(k_ra), .o_rdata(k_rd)
    );
    imh_ram #(.WIDTH(HW), .DEPTH(HEAP_DEPTH + 1)) u_s2h (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd)
    );
    imh_ram #(.WIDTH(SW), .DEPTH(MAX_HANDLES + 1)) u_h2s (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd)
    );

    // key narrowing / widening of the incoming value
    logic signed [KEY_BITS-1:0] w_in_key;
    generate
        if (KEY_BITS < VAL_W) begin : g_narrow
            assign w_in_key = $signed(i_req.new_value[KEY_BITS-1:0]);
        end else begin : g_wide
            assign w_in_key = KEY_BITS'(i_req.new_value);
        end
    endgenerate

    logic                       w_in_xfer, w_full, w_hdl_ok;
    logic [SW:0]                w_l, w_r;
    logic                       w_up_swap, w_bl, w_br, w_dn_go;
    logic signed [KEY_BITS-1:0] w_kb, w_ck;
    logic [HW-1:0]              w_ch;
    logic [SW-1:0]              w_cidx;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_xfer = i_req.valid && i_req.ready;
    assign w_full = (r_cnt >= SW'(HEAP_DEPTH)) || (r_iss >= HW'(MAX_HANDLES));
    assign w_hdl_ok = (i_req.handle != '0) && (CW'(i_req.handle) <= CW'(r_iss));

    assign w_l = {r_pos, 1'b0};
    assign w_r = w_l | (SW + 1)'(1);
    assign w_up_swap = r_key < $signed(k_rd);
    // pick the smaller child, strict compares, left first
    assign w_bl = r_kl < r_key;
    assign w_kb = w_bl ? r_kl : r_key;
    assign w_br = r_rok && ($signed(k_rd) < w_kb);
    assign w_dn_go = w_bl || w_br;
    assign w_ck = w_br ? $signed(k_rd) : r_kl;
    assign w_ch = w_br ? s_rd : r_hl;
    assign w_cidx = w_br ? w_r[SW-1:0] : w_l[SW-1:0];

    always_comb begin
        k_we = 1'b0; k_wa = r_pos; k_wd = r_key;
        s_we = 1'b0; s_wa = r_pos; s_wd = r_hdl;
        h_we = 1'b0; h_wa = r_hdl; h_wd = r_pos;
        k_ra = r_pos >> 1;
        s_ra = r_pos >> 1;
        h_ra = HW'(i_req.handle);
        unique case (r_state)
            S_IDLE: begin
                s_ra = SW'(1);
            end
            S_DM_HD, S_HS_RD: begin
                k_ra = r_cnt;
                s_ra = r_cnt;
            end
            S_RM_LAST: begin
                h_we = 1'b1; h_wa = r_hd; h_wd = '0;
            end
            S_UP_RD: ;
            S_UP_CMP: begin
                if (w_up_swap) begin
                    k_we = 1'b1; k_wd = k_rd;
                    s_we = 1'b1; s_wd = s_rd;
                    h_we = 1'b1; h_wa = s_rd;
                end
            end
            S_DN_RD: begin
                k_ra = w_l[SW-1:0];
                s_ra = w_l[SW-1:0];
            end
            S_DN_L: begin
                k_ra = w_r[SW-1:0];
                s_ra = w_r[SW-1:0];
            end
            S_DN_SEL: begin
                if (w_dn_go) begin
                    k_we = 1'b1; k_wd = w_ck;
                    s_we = 1'b1; s_wd = w_ch;
                    h_we = 1'b1; h_wa = w_ch;
                end
            end
            S_PLACE: begin
                k_we = 1'b1; s_we = 1'b1; h_we = 1'b1;
            end
            S_FIN: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_iss <= '0;
            r_ov <= 1'b0;
        end else begin
            // root cache follows every key write to slot one
            if (k_we && k_wa == SW'(1)) begin
                r_min <= $signed(k_wd);
            end
            // result taken; a new one loaded in S_FIN sets it again
            if (r_ov && o_rsp.ready && r_state != S_FIN) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_act <= i_req.action;
                        r_hd <= HW'(i_req.handle);
                        r_nkey <= w_in_key;
                        case (i_req.action)
                            ACT_INSERT: begin
                                if (w_full) begin
                                    r_status <= ST_FULL;
                                    r_state <= S_FIN;
                                end else begin
                                    r_status <= ST_OK;
                                    r_cnt <= r_cnt + SW'(1);
                                    r_iss <= r_iss + HW'(1);
                                    r_pos <= r_cnt + SW'(1);
                                    r_hdl <= r_iss + HW'(1);
                                    r_key <= w_in_key;
                                    r_state <= S_UP_RD;
                                end
                            end
                            ACT_PEEK: begin
                                r_status <= (r_cnt == '0) ? ST_EMPTY : ST_OK;
                                r_state <= S_FIN;
                            end
                            ACT_DEL_MIN: begin
                                if (r_cnt == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state <= S_FIN;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state <= S_DM_HD;
                                end
                            end
                            ACT_DEL_HDL, ACT_CHG_HDL: begin
                                if (w_hdl_ok) begin
                                    r_status <= ST_OK;
                                    r_state <= S_HS_RD;
                                end else begin
                                    r_status <= ST_BAD_HDL;
                                    r_state <= S_FIN;
                                end
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_DM_HD: begin
                    r_hd <= s_rd;
                    r_p <= SW'(1);
                    r_state <= S_RM_LAST;
                end
                S_HS_RD: begin
                    if (h_rd == '0) begin
                        r_status <= ST_BAD_HDL;
                        r_state <= S_FIN;
                    end else if (r_act == ACT_DEL_HDL) begin
                        r_p <= h_rd;
                        r_state <= S_RM_LAST;
                    end else begin
                        r_pos <= h_rd;
                        r_key <= r_nkey;
                        r_hdl <= r_hd;
                        r_state <= S_UP_RD;
                    end
                end
                S_RM_LAST: begin
                    // last entry moves into the hole unless the hole is last
                    r_cnt <= r_cnt - SW'(1);
                    if (r_p == r_cnt) begin
                        r_state <= S_FIN;
                    end else begin
                        r_pos <= r_p;
                        r_key <= $signed(k_rd);
                        r_hdl <= s_rd;
                        r_state <= S_UP_RD;
                    end
                end
                S_UP_RD: begin
                    r_state <= (r_pos == SW'(1)) ? S_DN_RD : S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (w_up_swap) begin
                        r_pos <= r_pos >> 1;
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= S_DN_RD;
                    end
                end
                S_DN_RD: begin
                    r_state <= (w_l > (SW + 1)'(r_cnt)) ? S_PLACE : S_DN_L;
                end
                S_DN_L: begin
                    r_kl <= $signed(k_rd);
                    r_hl <= s_rd;
                    r_rok <= (w_r <= (SW + 1)'(r_cnt));
                    r_state <= S_DN_SEL;
                end
                S_DN_SEL: begin
                    if (w_dn_go) begin
                        r_pos <= w_cidx;
                        r_state <= S_DN_RD;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: r_state <= S_FIN;
                S_FIN: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov <= 1'b1;
                        r_omin <= (r_cnt != '0) ? VAL_W'(r_min) : '0;
                        r_omv <= (r_cnt != '0);
                        r_ocnt <= CNT_OUT_W'(r_cnt);
                        r_ost <= r_status;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid = r_ov;
    assign o_rsp.min_value = r_omin;
    assign o_rsp.min_valid = r_omv;
    assign o_rsp.entry_count = r_ocnt;
    assign o_rsp.status = r_ost;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SW'(HEAP_DEPTH)) else $error("entry count above depth");
    a_cnt_iss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_cnt) <= CW'(r_iss)) else $error("more entries than handles issued");
    a_iss_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_iss >= $past(r_iss))) else $error("handle counter went back");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP || r_state == S_DN_SEL || r_state == S_PLACE)
        |-> (r_pos != '0 && r_pos <= r_cnt)) else $error("sift position out of range");
endmodule

// ----- src/imh_ram.sv -----
// imh_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
